>>> rtl/core/mcsd_pkg.sv
`default_nettype none

package mcsd_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = 2;

    localparam logic [31:0] ACC_MASK = 32'h7FFF7FFF;

    localparam int CFG_W = 31;

    typedef enum logic {
        CFG_PHASE_INC = 1'b0,
        CFG_PHASE_MOD = 1'b1
    } cfg_index_t;

    localparam logic [CFG_W-1:0] PHASE_INC_RESET = 31'd3241350;
    localparam logic [CFG_W-1:0] PHASE_MOD_RESET = 31'd420000000;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_TICK  = 1'b1
    } op_kind_t;

    typedef struct packed {
        logic        req_type;
        logic [14:0] word_address;
        logic [31:0] word_data;
    } in_word_t;

    typedef struct packed {
        logic [13:0] toggle_mask;
        logic [13:0] pin_levels;
        logic        frame_advanced;
        logic [14:0] frame_position;
    } out_word_t;

    typedef struct packed {
        op_kind_t    kind;
        logic [14:0] word_address;
        logic [31:0] word_data;
    } q_entry_t;

    typedef struct packed {
        logic     valid;
        q_entry_t entry;
    } q_head_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_STEP,
        BK_READ,
        BK_DRAIN
    } bk_state_t;

endpackage

`default_nettype wire

>>> rtl/core/mcsd_front.sv
`default_nettype none

module mcsd_front #(
    parameter int MEM_DEPTH = 32768
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  mcsd_pkg::in_word_t  s_data,
    output mcsd_pkg::q_head_t   q_head,
    input  wire                 q_pop
);

    localparam int QD = mcsd_pkg::QUEUE_DEPTH;
    localparam int PW = mcsd_pkg::QPTR_W;
    localparam int CNT_W = PW + 1;

    mcsd_pkg::q_entry_t fifo_reg [QD];
    logic [PW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    logic               keep;
    logic               push;
    logic               pop;
    mcsd_pkg::q_entry_t new_entry;

    // writes beyond the memory are taken and dropped here
    always_comb begin
        keep = (s_data.req_type == mcsd_pkg::OP_TICK) ||
               (32'(s_data.word_address) < 32'(MEM_DEPTH));
        push = s_valid && s_ready && keep;
        pop  = q_pop && q_head.valid;

        new_entry.kind         = mcsd_pkg::op_kind_t'(s_data.req_type);
        new_entry.word_address = s_data.word_address;
        new_entry.word_data    = s_data.word_data;

        wr_ptr_next = push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    assign s_ready      = (count_reg != CNT_W'(QD));
    assign q_head.valid = (count_reg != '0);
    assign q_head.entry = fifo_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= new_entry;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/mcsd_back.sv
`default_nettype none

module mcsd_back #(
    parameter int LANES     = 7,
    parameter int MEM_DEPTH = 32768
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          cfg_wr_en,
    input  wire                          cfg_index,
    input  wire [mcsd_pkg::CFG_W-1:0]    cfg_wdata,
    input  mcsd_pkg::q_head_t            q_head,
    output logic                         q_pop,
    output logic                         m_valid,
    input  wire                          m_ready,
    output mcsd_pkg::out_word_t          m_data
);

    localparam int AW    = $clog2(MEM_DEPTH);
    localparam int NP    = 2 * LANES;
    localparam int CW    = $clog2(LANES + 1);
    localparam int CFG_W = mcsd_pkg::CFG_W;
    localparam logic [AW-1:0]    LAST_ADDR = AW'(MEM_DEPTH - 1);
    localparam logic [LANES-1:0] LANE_TOP  = LANES'(1) << (LANES - 1);

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a);
        return (a == LAST_ADDR) ? '0 : a + AW'(1);
    endfunction

    mcsd_pkg::bk_state_t state_reg, state_next;

    logic [CFG_W-1:0] inc_reg, mod_reg;
    logic [31:0]      phase_reg, sum_reg;
    logic [AW-1:0]    frame_reg;
    logic             step_reg;
    logic [AW-1:0]    rd_addr_reg;
    logic [CW-1:0]    rd_cnt_reg;
    logic [31:0]      acc_reg [LANES];
    logic [LANES-1:0] dec_lo_reg, dec_hi_reg;
    logic [NP-1:0]    pin_reg, cl_reg, ch_reg;
    logic             out_valid_reg;
    mcsd_pkg::out_word_t out_reg;

    logic [31:0]      mem [MEM_DEPTH];
    logic [31:0]      rd_q_reg;

    logic             out_free;
    logic             mem_we, rd_en, load_sum, step_ld, lane_adv, finish;
    logic [AW-1:0]    wr_addr, rd_addr_issue, frame_inc;
    logic [31:0]      diff, phase_sub, q_sum;
    logic             step_now;
    logic [LANES-1:0] dec_lo_shift, dec_hi_shift;
    logic [NP-1:0]    want, carry0, carry1, pin_next;
    logic [15:0]      tog_w, pin_w, frame_w;

    always_comb begin
        out_free     = !out_valid_reg || m_ready;
        wr_addr      = AW'(q_head.entry.word_address);
        diff         = {1'b0, mod_reg} - sum_reg;
        step_now     = diff[31];
        phase_sub    = sum_reg - {1'b0, mod_reg};
        frame_inc    = wrap_inc(frame_reg);
        q_sum        = acc_reg[0] + rd_q_reg;
        dec_lo_shift = (dec_lo_reg >> 1) | (q_sum[15] ? LANE_TOP : '0);
        dec_hi_shift = (dec_hi_reg >> 1) | (q_sum[31] ? LANE_TOP : '0);
        // 2-bit mismatch counter per pin; toggle on wrap
        want         = {dec_hi_shift, dec_lo_shift} ^ pin_reg;
        carry0       = want & cl_reg;
        carry1       = carry0 & ch_reg;
        pin_next     = pin_reg ^ carry1;
        tog_w        = 16'(carry1);
        pin_w        = 16'(pin_next);
        frame_w      = 16'(frame_reg);
    end

    always_comb begin
        state_next    = state_reg;
        q_pop         = 1'b0;
        mem_we        = 1'b0;
        rd_en         = 1'b0;
        rd_addr_issue = rd_addr_reg;
        load_sum      = 1'b0;
        step_ld       = 1'b0;
        lane_adv      = 1'b0;
        finish        = 1'b0;
        case (state_reg)
            mcsd_pkg::BK_IDLE: begin
                if (q_head.valid) begin
                    q_pop = 1'b1;
                    if (q_head.entry.kind == mcsd_pkg::OP_WRITE) begin
                        mem_we = 1'b1;
                    end else begin
                        load_sum   = 1'b1;
                        state_next = mcsd_pkg::BK_STEP;
                    end
                end
            end
            mcsd_pkg::BK_STEP: begin
                step_ld       = 1'b1;
                rd_en         = 1'b1;
                rd_addr_issue = step_now ? frame_inc : frame_reg;
                state_next    = (LANES == 1) ? mcsd_pkg::BK_DRAIN : mcsd_pkg::BK_READ;
            end
            mcsd_pkg::BK_READ: begin
                rd_en    = 1'b1;
                lane_adv = 1'b1;
                if (rd_cnt_reg == CW'(LANES - 1)) begin
                    state_next = mcsd_pkg::BK_DRAIN;
                end
            end
            mcsd_pkg::BK_DRAIN: begin
                if (out_free) begin
                    lane_adv   = 1'b1;
                    finish     = 1'b1;
                    state_next = mcsd_pkg::BK_IDLE;
                end
            end
            default: begin
                state_next = mcsd_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= mcsd_pkg::BK_IDLE;
            inc_reg       <= mcsd_pkg::PHASE_INC_RESET;
            mod_reg       <= mcsd_pkg::PHASE_MOD_RESET;
            phase_reg     <= '0;
            frame_reg     <= '0;
            pin_reg       <= '0;
            cl_reg        <= '0;
            ch_reg        <= '0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < LANES; k++) begin
                acc_reg[k] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                if (cfg_index == mcsd_pkg::CFG_PHASE_INC) begin
                    inc_reg <= cfg_wdata;
                end else begin
                    mod_reg <= cfg_wdata;
                end
            end
            if (step_ld) begin
                phase_reg <= step_now ? phase_sub : sum_reg;
                frame_reg <= step_now ? frame_inc : frame_reg;
            end
            if (lane_adv) begin
                for (int k = 0; k < LANES - 1; k++) begin
                    acc_reg[k] <= acc_reg[k + 1];
                end
                acc_reg[LANES-1] <= q_sum & mcsd_pkg::ACC_MASK;
            end
            if (finish) begin
                cl_reg  <= cl_reg ^ want;
                ch_reg  <= ch_reg ^ carry0;
                pin_reg <= pin_next;
            end
            if (finish) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_sum) begin
            sum_reg <= phase_reg + {1'b0, inc_reg};
        end
        if (step_ld) begin
            step_reg   <= step_now;
            rd_cnt_reg <= CW'(1);
        end else if (rd_en) begin
            rd_cnt_reg <= rd_cnt_reg + CW'(1);
        end
        if (rd_en) begin
            rd_addr_reg <= wrap_inc(rd_addr_issue);
        end
        if (lane_adv) begin
            dec_lo_reg <= dec_lo_shift;
            dec_hi_reg <= dec_hi_shift;
        end
        if (finish) begin
            out_reg.toggle_mask    <= tog_w[13:0];
            out_reg.pin_levels     <= pin_w[13:0];
            out_reg.frame_advanced <= step_reg;
            out_reg.frame_position <= frame_w[14:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_addr] <= q_head.entry.word_data;
        end
        if (rd_en) begin
            rd_q_reg <= mem[rd_addr_issue];
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire

>>> rtl/core/multichannel_sigma_delta_pin_driver.sv
// Multichannel first-order delta-sigma pin driver, 2*LANES one-bit pins.
// Input channel (s_valid/s_ready/s_data): a word is either a sample write
// (req_type 0) into the sample memory or a modulator tick (req_type 1).
// Writes beyond MEM_DEPTH are taken and dropped. Writes give no result;
// each tick gives one result word on m_valid/m_ready/m_data.
// Configuration: cfg_wr_en with cfg_index 0 = phase increment,
// 1 = phase modulus; write only while the block is idle.
// Input words pass through a 4-entry queue to an execution sequencer, which
// sees a word in the cycle after the edge that took it. A write is done there
// in the idle state. A tick runs in steps: a phase add, a step that settles the
// frame step and issues the first lane read, the other lane reads on the single
// sample-memory read port, and a final step that adds the last lane and
// updates the pins. m_valid rises at the end of that final step. Ticks run one
// at a time: the next tick starts only after the last one's final step.
// Reset clears phase, frame index, lane accumulators and pin state and
// loads the register defaults; memory contents are kept as garbage and
// must be written before a tick reads them.
// A stalled result holds in the output register and the next tick waits in its
// final cycle; the queue keeps taking words until it fills, then s_ready drops.
`default_nettype none

module multichannel_sigma_delta_pin_driver #(
    parameter int LANES     = 7,
    parameter int MEM_DEPTH = 32768
) (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire                        cfg_wr_en,
    input  wire                        cfg_index,
    input  wire [mcsd_pkg::CFG_W-1:0]  cfg_wdata,
    input  wire                        s_valid,
    output logic                       s_ready,
    input  mcsd_pkg::in_word_t         s_data,
    output logic                       m_valid,
    input  wire                        m_ready,
    output mcsd_pkg::out_word_t        m_data
);

    mcsd_pkg::q_head_t q_head;
    logic              q_pop;

    mcsd_front #(
        .MEM_DEPTH(MEM_DEPTH)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_head  (q_head),
        .q_pop   (q_pop)
    );

    mcsd_back #(
        .LANES     (LANES),
        .MEM_DEPTH (MEM_DEPTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire

>>> rtl/core/mcsd_checker.sv
`default_nettype none

module mcsd_checker (
    input wire                  aclk,
    input wire                  aresetn,
    input wire                  m_valid,
    input wire                  m_ready,
    input mcsd_pkg::out_word_t  m_data
);

    logic [13:0] last_pins_reg;
    logic [14:0] last_pos_reg;

    // levels and frame position as of the last delivered word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_pins_reg <= '0;
            last_pos_reg  <= '0;
        end else if (m_valid && m_ready) begin
            last_pins_reg <= m_data.pin_levels;
            last_pos_reg  <= m_data.frame_position;
        end
    end

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_out_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    a_pins_follow_toggles: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.pin_levels == (last_pins_reg ^ m_data.toggle_mask))
        else $error("pin levels disagree with toggle mask");

    a_frame_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.frame_advanced |-> m_data.frame_position == last_pos_reg)
        else $error("frame moved without a step");

endmodule

bind multichannel_sigma_delta_pin_driver mcsd_checker u_mcsd_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
